### hw/rtl/mlfr_pkg.sv
// Shared types and constants for the motor link frame receiver.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package mlfr_pkg;

	// Fixed framing of the binary packet.
	localparam int unsigned PACKET_LEN = 7;
	localparam logic [7:0] HEADER_BYTE = 8'hA5;
	localparam logic [7:0] SPEED_FUNC  = 8'h02;

	// Characters of the text lines.
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Result kinds.
	localparam logic [1:0] KIND_SPEED   = 2'd0;
	localparam logic [1:0] KIND_ENCODER = 2'd1;
	localparam logic [1:0] KIND_ANGLE   = 2'd2;

	// Packet counter width (counts 0 to PACKET_LEN-1).
	localparam int unsigned PCNT_W = $clog2(PACKET_LEN);

	// One result item plus its valid flag.
	typedef struct packed {
		logic        vld;
		logic [1:0]  kind;
		logic [31:0] left_value;
		logic [31:0] right_value;
	} result_t;

	// Control of one number field parser.
	typedef struct packed {
		logic clr;
		logic feed;
	} field_ctl_t;

	// Status of the packet parser.
	typedef struct packed {
		logic              mode;
		logic [PCNT_W-1:0] count;
	} pkt_sts_t;

endpackage

### hw/rtl/mlfr_field.sv
// Parser for one decimal number field of a text line (integer or angle).
// Depends on mlfr_pkg for the character constants and the control struct.
`timescale 1ns / 1ps

module mlfr_field (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mlfr_pkg::field_ctl_t   ctl,
	input  logic [7:0]             ch,
	input  logic                   angle,
	output logic [31:0]            value
);

	localparam logic [2:0] PH_SPACE = 3'd0;
	localparam logic [2:0] PH_SIGN  = 3'd1;
	localparam logic [2:0] PH_WHOLE = 3'd2;
	localparam logic [2:0] PH_FRAC  = 3'd3;
	localparam logic [2:0] PH_DONE  = 3'd4;

	logic [2:0]  phase_q, e_phase, n_phase;
	logic        neg_q, e_neg, n_neg;
	logic [31:0] whole_q, e_whole, n_whole;
	logic [6:0]  frac_q, e_frac, n_frac;
	logic [1:0]  fdig_q, e_fdig, n_fdig;

	logic        is_digit;
	logic        is_blank;
	logic        is_sign;
	logic        is_dot;
	logic [3:0]  dval;
	logic [31:0] whole_x10;
	logic [9:0]  frac_x10;
	logic [6:0]  frac_scaled;
	logic [31:0] mag;

	// Character classes.
	assign is_digit = (ch >= mlfr_pkg::CH_ZERO) && (ch <= mlfr_pkg::CH_NINE);
	assign is_blank = (ch == mlfr_pkg::CH_SPACE) ||
		((ch >= mlfr_pkg::CH_TAB) && (ch <= mlfr_pkg::CH_CR));
	assign is_sign  = (ch == mlfr_pkg::CH_PLUS) || (ch == mlfr_pkg::CH_MINUS);
	assign is_dot   = (ch == mlfr_pkg::CH_DOT);
	assign dval     = is_digit ? ch[3:0] : 4'd0;

	// The clear comes first, then the character is applied to the cleared state.
	always_comb begin
		e_phase = ctl.clr ? PH_SPACE : phase_q;
		e_neg   = ctl.clr ? 1'b0 : neg_q;
		e_whole = ctl.clr ? 32'd0 : whole_q;
		e_frac  = ctl.clr ? 7'd0 : frac_q;
		e_fdig  = ctl.clr ? 2'd0 : fdig_q;
	end

	assign whole_x10 = {e_whole[28:0], 3'b000} + {e_whole[30:0], 1'b0};
	assign frac_x10  = {e_frac, 3'b000} + {2'b00, e_frac, 1'b0};

	// Next state of the number grammar.
	always_comb begin
		n_phase = e_phase;
		n_neg   = e_neg;
		n_whole = e_whole;
		n_frac  = e_frac;
		n_fdig  = e_fdig;
		if (ctl.feed) begin
			case (e_phase)
				PH_SPACE, PH_SIGN: begin
					if ((e_phase == PH_SPACE) && is_blank) begin
						n_phase = e_phase;
					end else if ((e_phase == PH_SPACE) && is_sign) begin
						n_neg   = (ch == mlfr_pkg::CH_MINUS);
						n_phase = PH_SIGN;
					end else if (is_digit) begin
						n_whole = {28'd0, dval};
						n_phase = PH_WHOLE;
					end else if (is_dot) begin
						n_phase = PH_FRAC;
					end else begin
						n_phase = PH_DONE;
					end
				end
				PH_WHOLE: begin
					if (is_digit) begin
						n_whole = whole_x10 + {28'd0, dval};
					end else if (is_dot) begin
						n_phase = PH_FRAC;
					end else begin
						n_phase = PH_DONE;
					end
				end
				PH_FRAC: begin
					if (is_digit) begin
						if (e_fdig < 2'd2) begin
							n_frac = 7'(frac_x10 + {6'd0, dval});
							n_fdig = e_fdig + 2'd1;
						end
					end else begin
						n_phase = PH_DONE;
					end
				end
				default: begin
					n_phase = e_phase;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			whole_q <= 32'd0;
			frac_q  <= 7'd0;
			fdig_q  <= 2'd0;
		end else begin
			phase_q <= n_phase;
			neg_q   <= n_neg;
			whole_q <= n_whole;
			frac_q  <= n_frac;
			fdig_q  <= n_fdig;
		end
	end

	// Field value: an angle is whole*100 plus the fraction in hundredths.
	assign frac_scaled = (fdig_q == 2'd1) ? 7'({frac_q, 3'b000} + {2'b00, frac_q, 1'b0})
		: frac_q;
	assign mag = angle ? ({whole_q[25:0], 6'd0} + {whole_q[26:0], 5'd0} +
		{whole_q[29:0], 2'd0} + {25'd0, frac_scaled}) : whole_q;
	assign value = neg_q ? (32'd0 - mag) : mag;

endmodule

### hw/rtl/mlfr_packet.sv
// Parser for the seven-byte binary speed packet with its additive checksum.
// Depends on mlfr_pkg for the framing constants, result and status structs.
`timescale 1ns / 1ps

module mlfr_packet (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           ch,
	output mlfr_pkg::pkt_sts_t   sts,
	output mlfr_pkg::result_t    res
);

	localparam logic [mlfr_pkg::PCNT_W-1:0] LAST_CNT = mlfr_pkg::PCNT_W'(mlfr_pkg::PACKET_LEN - 1);

	logic                       mode_q;
	logic [mlfr_pkg::PCNT_W-1:0] count_q;
	logic [7:0]                 sum_q;
	logic [7:0]                 bytes_q [0:4];
	logic                       is_hdr;
	logic                       at_end;
	logic [mlfr_pkg::PCNT_W-1:0] wr_idx;

	assign is_hdr = (ch == mlfr_pkg::HEADER_BYTE);
	assign at_end = (count_q >= LAST_CNT);
	assign wr_idx = count_q - 1'b1;

	// Packet control: header starts, the checksum byte ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			count_q <= '0;
			sum_q   <= 8'd0;
		end else if (step) begin
			if (is_hdr) begin
				mode_q  <= 1'b1;
				count_q <= mlfr_pkg::PCNT_W'(1);
				sum_q   <= mlfr_pkg::HEADER_BYTE;
			end else if (mode_q) begin
				if (at_end) begin
					mode_q  <= 1'b0;
					count_q <= '0;
					sum_q   <= 8'd0;
				end else begin
					count_q <= count_q + 1'b1;
					sum_q   <= sum_q + ch;
				end
			end
		end
	end

	// Packet bytes two to six; each is written before the checksum is seen.
	always_ff @(posedge clk) begin
		if (step && !is_hdr && mode_q && !at_end) begin
			bytes_q[wr_idx] <= ch;
		end
	end

	// Result on a good checksum with the speed function code.
	always_comb begin
		res.vld         = step && !is_hdr && mode_q && at_end &&
			(sum_q == ch) && (bytes_q[0] == mlfr_pkg::SPEED_FUNC);
		res.kind        = mlfr_pkg::KIND_SPEED;
		res.left_value  = {{16{bytes_q[1][7]}}, bytes_q[1], bytes_q[2]};
		res.right_value = {{16{bytes_q[3][7]}}, bytes_q[3], bytes_q[4]};
	end

	assign sts.mode  = mode_q;
	assign sts.count = count_q;

endmodule

### hw/rtl/motor_link_frame_receiver.sv
// Top level of the motor link frame receiver: input register, line control,
// packet and field parsers, result register. Depends on mlfr_pkg, mlfr_packet, mlfr_field.
`timescale 1ns / 1ps

// The receiver takes one received link byte per item and delivers at most one
// result item per byte: a speed pair from a checked binary packet (kind 0), or
// an encoder pair (kind 1) or angle pair in hundredths of a degree (kind 2)
// from a comma separated text line ended by newline. It accepts one item every
// clock cycle unless output backpressure holds it; a result passes through the
// input register and then the result register, and all parse state is updated
// in the single step between them. Output backpressure stalls the input
// register, and the input side keeps taking items while the result
// register is free or being emptied. LINE_LEN sets the longest text line.
module motor_link_frame_receiver #(
	parameter int unsigned LINE_LEN = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic signed [31:0] left_value,
	output logic signed [31:0] right_value
);

	localparam int unsigned LC_W = $clog2(LINE_LEN);
	localparam logic [LC_W-1:0] LINE_LAST = LC_W'(LINE_LEN - 1);

	logic                 vld_s1;
	logic [7:0]           byte_s1;
	logic                 adv;
	logic                 is_hdr;
	logic                 is_nl;
	logic                 line_step;
	logic                 restart;
	logic                 comma_base;
	logic                 dot_base;
	logic [LC_W-1:0]      cnt_base;
	logic [LC_W-1:0]      line_cnt_q;
	logic                 comma_q;
	logic                 dot_q;
	mlfr_pkg::pkt_sts_t   pkt_sts;
	mlfr_pkg::result_t    pkt_res;
	mlfr_pkg::result_t    res;
	mlfr_pkg::field_ctl_t ctl0;
	mlfr_pkg::field_ctl_t ctl1;
	logic [31:0]          val0;
	logic [31:0]          val1;
	logic [1:0]           kind_q;
	logic [31:0]          left_q;
	logic [31:0]          right_q;

	// Handshake: stage one moves on when the result register is free or drains.
	assign adv      = vld_s1 && (!out_valid || out_ready);
	assign in_ready = !vld_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// Line control: a full line restarts with the new byte.
	assign is_hdr     = (byte_s1 == mlfr_pkg::HEADER_BYTE);
	assign is_nl      = (byte_s1 == mlfr_pkg::CH_NL);
	assign line_step  = adv && !is_hdr && !pkt_sts.mode;
	assign restart    = (line_cnt_q >= LINE_LAST);
	assign comma_base = restart ? 1'b0 : comma_q;
	assign dot_base   = restart ? 1'b0 : dot_q;
	assign cnt_base   = restart ? '0 : line_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_cnt_q <= '0;
			comma_q    <= 1'b0;
			dot_q      <= 1'b0;
		end else if (adv && is_hdr) begin
			line_cnt_q <= '0;
			comma_q    <= 1'b0;
			dot_q      <= 1'b0;
		end else if (line_step) begin
			if (is_nl) begin
				line_cnt_q <= '0;
				comma_q    <= 1'b0;
				dot_q      <= 1'b0;
			end else begin
				line_cnt_q <= cnt_base + 1'b1;
				comma_q    <= comma_base || (byte_s1 == mlfr_pkg::CH_COMMA);
				dot_q      <= dot_base || (byte_s1 == mlfr_pkg::CH_DOT);
			end
		end
	end

	// Field controls: the second field only sees bytes after the first comma.
	always_comb begin
		ctl0.clr  = (adv && is_hdr) || (line_step && (restart || is_nl));
		ctl0.feed = line_step && !is_nl;
		ctl1.clr  = ctl0.clr;
		ctl1.feed = line_step && !is_nl && comma_base;
	end

	mlfr_packet u_packet (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.ch     (byte_s1),
		.sts    (pkt_sts),
		.res    (pkt_res)
	);

	mlfr_field u_field0 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl0),
		.ch     (byte_s1),
		.angle  (dot_q),
		.value  (val0)
	);

	mlfr_field u_field1 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl1),
		.ch     (byte_s1),
		.angle  (dot_q),
		.value  (val1)
	);

	// Result selection: packet result, or a line result at newline.
	always_comb begin
		if (line_step && is_nl && comma_base) begin
			res.vld         = 1'b1;
			res.kind        = dot_q ? mlfr_pkg::KIND_ANGLE : mlfr_pkg::KIND_ENCODER;
			res.left_value  = val0;
			res.right_value = val1;
		end else begin
			res = pkt_res;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= res.vld;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.vld) begin
			kind_q  <= res.kind;
			left_q  <= res.left_value;
			right_q <= res.right_value;
		end
	end

	assign kind        = kind_q;
	assign left_value  = left_q;
	assign right_value = right_q;

	// A new result only ever comes from an item leaving the input register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (!$past(out_valid) || $past(out_ready))) |-> $past(adv))
		else $error("result register loaded without an item");

	// The held line never grows past its limit.
	a_line_limit: assert property (@(posedge clk) disable iff (!arst_n)
		line_cnt_q <= LINE_LAST)
		else $error("line count past limit");

	// Inside a packet the byte counter stays between the header and the checksum.
	a_packet_count: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_sts.mode |-> ((pkt_sts.count != '0) &&
			(pkt_sts.count <= mlfr_pkg::PCNT_W'(mlfr_pkg::PACKET_LEN - 1))))
		else $error("packet count out of range");

	// A valid result never carries an unused kind code.
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((kind == mlfr_pkg::KIND_SPEED) || (kind == mlfr_pkg::KIND_ENCODER) ||
			(kind == mlfr_pkg::KIND_ANGLE)))
		else $error("unused result kind");

endmodule

### test/tb_motor_link_frame_receiver.sv
// Self-checking testbench for the motor link frame receiver: sends link bytes,
// predicts speed, encoder and angle results, and checks them. Depends on mlfr_pkg.
`timescale 1ns / 1ps

module tb_motor_link_frame_receiver;

	localparam int LINE_LEN    = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_BYTES = 200;

	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;

	// Phases of one number field while a line is parsed.
	typedef enum logic [2:0] {PH_LEAD, PH_SIGN, PH_INT, PH_FRAC, PH_DONE} phase_t;

	// One decoded reading as the block should deliver it.
	typedef struct {
		logic [1:0]  kind;
		logic [31:0] left;
		logic [31:0] right;
	} reading_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         kind;
	logic signed [31:0] left_value;
	logic signed [31:0] right_value;

	motor_link_frame_receiver #(.LINE_LEN(LINE_LEN)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.left_value(left_value),
		.right_value(right_value)
	);

	reading_t awaited_readings[$];
	logic [7:0] line_text[$];

	int cycle_count;
	int error_count;
	int bytes_sent;
	int random_bytes;
	int readings_seen;
	int speed_seen;
	int encoder_seen;
	int angle_seen;
	int burst_left;
	int hold_request;
	int hold_left;
	int stall_left;
	int stall_mode;

	// Decoder state kept alongside the block.
	bit          pk_active;
	int unsigned pk_taken;
	logic [7:0]  pk_body[5];
	logic [7:0]  pk_sum;
	int unsigned ln_len;
	bit          ln_comma;
	bit          ln_dot;
	phase_t      fld_phase[2];
	bit          fld_neg[2];
	logic [31:0] fld_int[2];
	logic [6:0]  fld_frac[2];
	logic [1:0]  fld_nfrac[2];

	function automatic void packet_clear();
		pk_active = 0;
		pk_taken = 0;
		pk_sum = 8'h00;
		for (int i = 0; i < 5; i++) pk_body[i] = 8'h00;
	endfunction

	function automatic void line_clear();
		ln_len = 0;
		ln_comma = 0;
		ln_dot = 0;
		for (int k = 0; k < 2; k++) begin
			fld_phase[k] = PH_LEAD;
			fld_neg[k] = 0;
			fld_int[k] = '0;
			fld_frac[k] = '0;
			fld_nfrac[k] = '0;
		end
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == mlfr_pkg::CH_SPACE ||
			(c >= mlfr_pkg::CH_TAB && c <= mlfr_pkg::CH_CR);
	endfunction

	// Advances one number field by one character.
	function automatic void field_take(int k, logic [7:0] c);
		bit digit;
		logic [31:0] d;
		digit = c >= mlfr_pkg::CH_ZERO && c <= mlfr_pkg::CH_NINE;
		d = digit ? 32'(c - mlfr_pkg::CH_ZERO) : 32'd0;
		case (fld_phase[k])
			PH_LEAD, PH_SIGN: begin
				if (fld_phase[k] == PH_LEAD && is_blank(c)) begin
				end else if (fld_phase[k] == PH_LEAD &&
						(c == mlfr_pkg::CH_PLUS || c == mlfr_pkg::CH_MINUS)) begin
					fld_neg[k] = c == mlfr_pkg::CH_MINUS;
					fld_phase[k] = PH_SIGN;
				end else if (digit) begin
					fld_int[k] = d;
					fld_phase[k] = PH_INT;
				end else if (c == mlfr_pkg::CH_DOT) begin
					fld_phase[k] = PH_FRAC;
				end else begin
					fld_phase[k] = PH_DONE;
				end
			end
			PH_INT: begin
				if (digit)
					fld_int[k] = fld_int[k] * 10 + d;
				else if (c == mlfr_pkg::CH_DOT)
					fld_phase[k] = PH_FRAC;
				else
					fld_phase[k] = PH_DONE;
			end
			PH_FRAC: begin
				if (digit) begin
					if (fld_nfrac[k] < 2) begin
						fld_frac[k] = fld_frac[k] * 10 + d;
						fld_nfrac[k] = fld_nfrac[k] + 1;
					end
				end else begin
					fld_phase[k] = PH_DONE;
				end
			end
			default: begin
			end
		endcase
	endfunction

	// Value of one field, scaled to hundredths for angles, wrapping at 32 bits.
	function automatic logic [31:0] field_result(int k, bit angle);
		logic [31:0] mag;
		logic [31:0] frac;
		mag = fld_int[k];
		if (angle) begin
			frac = 32'(fld_frac[k]);
			if (fld_nfrac[k] == 1)
				frac = frac * 10;
			mag = mag * 100 + frac;
		end
		if (fld_neg[k])
			mag = 32'd0 - mag;
		return mag;
	endfunction

	// Updates the decoder with one accepted byte and queues any reading it completes.
	function automatic void decode_byte(logic [7:0] c);
		reading_t r;
		if (c == mlfr_pkg::HEADER_BYTE) begin
			packet_clear();
			line_clear();
			pk_active = 1;
			pk_taken = 1;
			pk_sum = mlfr_pkg::HEADER_BYTE;
			return;
		end
		if (pk_active) begin
			if (pk_taken >= mlfr_pkg::PACKET_LEN - 1) begin
				if (pk_sum == c && pk_body[0] == mlfr_pkg::SPEED_FUNC) begin
					r.kind = mlfr_pkg::KIND_SPEED;
					r.left = {{16{pk_body[1][7]}}, pk_body[1], pk_body[2]};
					r.right = {{16{pk_body[3][7]}}, pk_body[3], pk_body[4]};
					awaited_readings.push_back(r);
				end
				packet_clear();
				return;
			end
			if (pk_taken >= 1 && pk_taken <= 5)
				pk_body[pk_taken - 1] = c;
			pk_sum = pk_sum + c;
			pk_taken++;
			return;
		end
		if (ln_len >= LINE_LEN - 1)
			line_clear();
		ln_len++;
		if (c == mlfr_pkg::CH_NL) begin
			if (ln_comma) begin
				r.kind = ln_dot ? mlfr_pkg::KIND_ANGLE : mlfr_pkg::KIND_ENCODER;
				r.left = field_result(0, ln_dot);
				r.right = field_result(1, ln_dot);
				awaited_readings.push_back(r);
			end
			line_clear();
			return;
		end
		if (c == mlfr_pkg::CH_DOT)
			ln_dot = 1;
		field_take(0, c);
		if (ln_comma)
			field_take(1, c);
		else if (c == mlfr_pkg::CH_COMMA)
			ln_comma = 1;
	endfunction

	// Clock and the cycle watchdog.
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d readings outstanding.",
				cycle_count, awaited_readings.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 40)
			$display("MISMATCH cycle %0d: %s", cycle_count, msg);
	endtask

	// Compares each delivered reading with the oldest prediction.
	always @(posedge clk) begin : check_readings
		reading_t want;
		if (arst_n && out_valid && out_ready) begin
			readings_seen++;
			case (kind)
				mlfr_pkg::KIND_SPEED: speed_seen++;
				mlfr_pkg::KIND_ENCODER: encoder_seen++;
				mlfr_pkg::KIND_ANGLE: angle_seen++;
				default: begin
				end
			endcase
			if (awaited_readings.size() == 0) begin
				report_mismatch($sformatf("unexpected reading kind %0d (%0d, %0d)",
					kind, left_value, right_value));
			end else begin
				want = awaited_readings.pop_front();
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
				if (left_value !== want.left)
					report_mismatch($sformatf("left_value %0d, expected %0d",
						left_value, $signed(want.left)));
				if (right_value !== want.right)
					report_mismatch($sformatf("right_value %0d, expected %0d",
						right_value, $signed(want.right)));
			end
		end
	end

	// Output side: a long hold-off on request, otherwise segments of steady,
	// random or mostly stalled readiness.
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 0;
			end else begin
				if (stall_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					stall_left = $urandom_range(5, 60);
				end
				stall_left--;
				case (stall_mode)
					0: out_ready <= 1;
					1: out_ready <= $urandom_range(0, 1);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Offers one item, with bursts and gaps, and predicts it once accepted.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 0;
			end
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		in_valid <= 1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		decode_byte(b);
		bytes_sent++;
		burst_left--;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_line_text();
		foreach (line_text[i])
			send_byte(line_text[i]);
		line_text.delete();
	endtask

	// Sends a full packet; a corrupted one carries a wrong checksum.
	task automatic send_packet(input logic [7:0] func, input logic [15:0] l,
			input logic [15:0] r, input bit corrupt);
		logic [7:0] body[6];
		logic [7:0] sum;
		body = '{mlfr_pkg::HEADER_BYTE, func, l[15:8], l[7:0], r[15:8], r[7:0]};
		sum = 8'h00;
		foreach (body[i]) begin
			sum = sum + body[i];
			send_byte(body[i]);
		end
		if (corrupt)
			sum = sum ^ 8'($urandom_range(1, 255));
		send_byte(sum);
	endtask

	// Appends one random number field to the line being built.
	function automatic void add_field(bit angle);
		logic [7:0] blanks[6];
		int n;
		blanks = '{mlfr_pkg::CH_SPACE, mlfr_pkg::CH_TAB, CH_VT, CH_FF, mlfr_pkg::CH_CR,
			mlfr_pkg::CH_SPACE};
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
			line_text.push_back(blanks[$urandom_range(0, 5)]);
		case ($urandom_range(0, 2))
			1: line_text.push_back(mlfr_pkg::CH_PLUS);
			2: line_text.push_back(mlfr_pkg::CH_MINUS);
			default: begin
			end
		endcase
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 5);
		repeat (n) line_text.push_back(mlfr_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
		if (angle && $urandom_range(0, 3) != 0) begin
			line_text.push_back(mlfr_pkg::CH_DOT);
			repeat ($urandom_range(0, 4))
				line_text.push_back(mlfr_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
		end
		if ($urandom_range(0, 7) == 0)
			line_text.push_back(8'($urandom_range(8'h20, 8'h7E)));
	endfunction

	// Binary speed packets, including the sign extremes.
	task automatic test_speed_packets();
		send_packet(mlfr_pkg::SPEED_FUNC, 16'h8000, 16'h7FFF, 0);
		send_packet(mlfr_pkg::SPEED_FUNC, 16'h0000, 16'hFFFF, 0);
	endtask

	// Bad checksum, other function byte and a header arriving mid-packet or mid-line.
	task automatic test_packet_faults();
		send_packet(mlfr_pkg::SPEED_FUNC, 16'h1234, 16'h5678, 1);
		send_packet(8'h03, 16'h1234, 16'h5678, 0);
		send_byte(mlfr_pkg::HEADER_BYTE);
		send_byte(mlfr_pkg::SPEED_FUNC);
		send_byte(8'h12);
		send_packet(mlfr_pkg::SPEED_FUNC, 16'hFF01, 16'h0102, 0);
		send_text("12,3");
		send_packet(mlfr_pkg::SPEED_FUNC, 16'h0001, 16'h8001, 0);
	endtask

	// Encoder and angle lines and their odd corners.
	task automatic test_text_lines();
		send_text("-12,+34\n");
		send_text(" \t1.5,-0.125\n");
		send_text("abc,\n");
		send_text("123\n");
		send_text("4294967297,-2147483649\n");
		send_text("1e5,.5\n");
		send_text("7,8,9\n");
		send_text("-.5,+.05\n");
		send_text("5");
		send_byte(8'h00);
		send_text(",6\n");
	endtask

	// Lines just below and at the length limit.
	task automatic test_line_limits();
		send_text("1,2");
		repeat (LINE_LEN - 5) send_byte("x");
		send_byte(mlfr_pkg::CH_NL);
		send_text("9,9");
		repeat (LINE_LEN - 4) send_byte("x");
		send_text("3,4\n");
	endtask

	// Output held off for a long stretch while lines keep arriving.
	task automatic test_backpressure();
		hold_request = HOLD_CYCLES;
		repeat (12) send_text("1,-2\n");
	endtask

	// Mostly well-formed packets and lines with random content, some noise.
	task automatic test_random_traffic();
		int pick;
		int start;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				send_packet(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
					mlfr_pkg::SPEED_FUNC,
					16'($urandom), 16'($urandom), $urandom_range(0, 9) == 0);
			end else if (pick < 85) begin
				add_field($urandom_range(0, 1));
				if ($urandom_range(0, 9) != 0)
					line_text.push_back(mlfr_pkg::CH_COMMA);
				add_field($urandom_range(0, 1));
				line_text.push_back(mlfr_pkg::CH_NL);
				send_line_text();
			end else if (pick < 92) begin
				repeat ($urandom_range(55, 75))
					line_text.push_back(8'($urandom_range(8'h20, 8'h7E)));
				send_line_text();
				send_text("-7,8\n");
			end else begin
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
			end
		end
		random_bytes = bytes_sent - start;
	endtask

	// Test sequence.
	initial begin
		arst_n = 0;
		in_valid = 0;
		rx_byte = 8'h00;
		packet_clear();
		line_clear();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		test_speed_packets();
		test_packet_faults();
		test_text_lines();
		test_line_limits();
		test_backpressure();
		test_random_traffic();

		@(negedge clk);
		in_valid <= 0;
		while (awaited_readings.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (awaited_readings.size() != 0)
			report_mismatch($sformatf("%0d readings never arrived", awaited_readings.size()));

		$display("Run: %0d bytes (%0d random), %0d readings: %0d speed, %0d encoder, %0d angle.",
			bytes_sent, random_bytes, readings_seen, speed_seen, encoder_seen, angle_seen);
		$display("Covered faulty packets, header restarts, long lines, noise and a %0d-cycle stall.",
			HOLD_CYCLES);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
